@@ rtl/core/qas_pkg.sv @@
// Package for the quoted argument splitter.
// Holds the character codes and quote mode codes; depends on nothing.
`timescale 1ns / 1ps

package qas_pkg;

    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_CR        = 8'h0D;
    localparam logic [7:0] CHAR_LF        = 8'h0A;
    localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
    localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_DQ    = 2'd1;
    localparam logic [1:0] MODE_SQ    = 2'd2;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       token_end;
    } result_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_CR) || (c == CHAR_LF);
    endfunction

endpackage

@@ rtl/core/quoted_argument_splitter.sv @@
// Top level of the quoted argument splitter: tokenizer logic and output skid buffer.
// Depends on qas_pkg for character codes, mode codes and the result type.
`timescale 1ns / 1ps

// Splits a command string, one byte per item with the final byte marked by in_last,
// into shell-style arguments with double quotes, single quotes and backslash escapes.
// Each accepted item yields zero or one result: an argument byte (byte_valid 1) or
// an end marker (byte_valid 0, token_end 1); the last byte of a string always closes
// the open argument and returns the block to plain mode. The block takes one item
// per clock cycle while in_stall is low, and each result is registered before it leaves. A
// two-entry output stage (result register plus skid register) lets input continue
// while a result waits; in_stall rises only when both entries are full.
module quoted_argument_splitter
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       token_end
);

    logic [1:0]         mode_reg;
    logic [1:0]         mode_next;
    logic               escape_reg;
    logic               escape_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               skid_valid_reg;
    logic               skid_valid_next;
    qas_pkg::result_t   out_reg;
    qas_pkg::result_t   out_next;
    qas_pkg::result_t   skid_reg;
    qas_pkg::result_t   skid_next;
    qas_pkg::result_t   res;

    logic in_take;
    logic out_take;
    logic emitted;
    logic closed;
    logic produce;
    logic [1:0] mode_step;

    assign in_stall = skid_valid_reg;
    assign in_take  = in_valid && !skid_valid_reg;
    assign out_take = out_valid_reg && !out_stall;

    // Every byte opens an argument, so an open argument is always present at
    // the end of a string; no separate open flag needs to be stored.
    always_comb
    begin
        emitted   = 1'b0;
        closed    = 1'b0;
        mode_step = mode_reg;
        escape_next = escape_reg;
        if (escape_reg)
        begin
            escape_next = 1'b0;
            emitted     = 1'b1;
        end
        else if (in_byte == qas_pkg::CHAR_BACKSLASH)
        begin
            escape_next = 1'b1;
        end
        else
        begin
            case (mode_reg)
                qas_pkg::MODE_DQ:
                begin
                    if (in_byte == qas_pkg::CHAR_DQUOTE)
                    begin
                        mode_step = qas_pkg::MODE_PLAIN;
                        closed    = 1'b1;
                    end
                    else
                    begin
                        emitted = 1'b1;
                    end
                end
                qas_pkg::MODE_SQ:
                begin
                    if (in_byte == qas_pkg::CHAR_SQUOTE)
                    begin
                        mode_step = qas_pkg::MODE_PLAIN;
                        closed    = 1'b1;
                    end
                    else
                    begin
                        emitted = 1'b1;
                    end
                end
                default:
                begin
                    mode_step = qas_pkg::MODE_PLAIN;
                    if (qas_pkg::is_blank(in_byte))
                    begin
                        closed = 1'b1;
                    end
                    else if (in_byte == qas_pkg::CHAR_DQUOTE)
                    begin
                        mode_step = qas_pkg::MODE_DQ;
                    end
                    else if (in_byte == qas_pkg::CHAR_SQUOTE)
                    begin
                        mode_step = qas_pkg::MODE_SQ;
                    end
                    else
                    begin
                        emitted = 1'b1;
                    end
                end
            endcase
        end

        if (in_last)
        begin
            mode_next   = qas_pkg::MODE_PLAIN;
            escape_next = 1'b0;
        end
        else
        begin
            mode_next = mode_step;
        end

        produce = closed || emitted || in_last;
        res.out_byte   = (emitted && !closed) ? in_byte : 8'd0;
        res.byte_valid = emitted && !closed;
        res.token_end  = closed || in_last;
    end

    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_take && produce)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= qas_pkg::MODE_PLAIN;
            escape_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                mode_reg   <= mode_next;
                escape_reg <= escape_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_reg.out_byte;
    assign byte_valid = out_reg.byte_valid;
    assign token_end  = out_reg.token_end;

endmodule

@@ bench/tb.sv @@
// Testbench for quoted_argument_splitter: directed and random command strings,
// with a scoreboard that predicts each argument byte and argument end.
// Depends on qas_pkg and the quoted_argument_splitter RTL.
`timescale 1ns / 1ps

typedef logic [7:0] byte_q_t[$];

function automatic bit is_separator(input logic [7:0] c);
    return c == qas_pkg::CHAR_SPACE || c == qas_pkg::CHAR_TAB ||
           c == qas_pkg::CHAR_CR || c == qas_pkg::CHAR_LF;
endfunction

class argument_scoreboard;
    logic [1:0]       quote_mode;
    bit               escape_pending;
    bit               token_open;
    qas_pkg::result_t expected_q[$];
    int               errors;
    int               results_checked;

    function new();
        quote_mode      = qas_pkg::MODE_PLAIN;
        escape_pending  = 0;
        token_open      = 0;
        errors          = 0;
        results_checked = 0;
    endfunction

    // Runs one accepted item through the tokenizer rules and queues its result.
    function void note_input(input logic [7:0] c, input logic last);
        logic [1:0] mode;
        bit         emitted;
        bit         closed;
        logic [7:0] b;
        mode    = quote_mode;
        emitted = 0;
        closed  = 0;
        b       = 8'h00;
        token_open = 1;
        if (escape_pending)
        begin
            escape_pending = 0;
            b = c;
            emitted = 1;
        end
        else if (c == qas_pkg::CHAR_BACKSLASH)
        begin
            escape_pending = 1;
        end
        else
        begin
            case (mode)
                qas_pkg::MODE_DQ:
                begin
                    if (c == qas_pkg::CHAR_DQUOTE)
                    begin
                        mode = qas_pkg::MODE_PLAIN;
                        closed = 1;
                    end
                    else
                    begin
                        b = c;
                        emitted = 1;
                    end
                end
                qas_pkg::MODE_SQ:
                begin
                    if (c == qas_pkg::CHAR_SQUOTE)
                    begin
                        mode = qas_pkg::MODE_PLAIN;
                        closed = 1;
                    end
                    else
                    begin
                        b = c;
                        emitted = 1;
                    end
                end
                default:
                begin
                    if (is_separator(c))
                        closed = 1;
                    else if (c == qas_pkg::CHAR_DQUOTE)
                        mode = qas_pkg::MODE_DQ;
                    else if (c == qas_pkg::CHAR_SQUOTE)
                        mode = qas_pkg::MODE_SQ;
                    else
                    begin
                        b = c;
                        emitted = 1;
                    end
                end
            endcase
        end

        if (closed)
        begin
            token_open = 0;
            expected_q.push_back('{8'h00, 1'b0, 1'b1});
        end
        else if (emitted)
        begin
            expected_q.push_back('{b, 1'b1, last});
            if (last)
                token_open = 0;
        end
        else if (last && token_open)
        begin
            expected_q.push_back('{8'h00, 1'b0, 1'b1});
            token_open = 0;
        end

        quote_mode = mode;
        // The marked last byte returns everything to the idle state.
        if (last)
        begin
            quote_mode     = qas_pkg::MODE_PLAIN;
            escape_pending = 0;
            token_open     = 0;
        end
    endfunction

    function void check_result(input logic [7:0] ob, input logic bv, input logic te);
        qas_pkg::result_t exp_r;
        results_checked++;
        if (expected_q.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("ERROR %0t: unexpected result byte=%02h valid=%0b end=%0b",
                         $realtime, ob, bv, te);
            return;
        end
        exp_r = expected_q.pop_front();
        if (ob !== exp_r.out_byte || bv !== exp_r.byte_valid || te !== exp_r.token_end)
        begin
            errors++;
            if (errors <= 10)
                $display({"ERROR %0t: expected byte=%02h valid=%0b end=%0b, ",
                          "got byte=%02h valid=%0b end=%0b"},
                         $realtime, exp_r.out_byte, exp_r.byte_valid, exp_r.token_end,
                         ob, bv, te);
        end
    endfunction
endclass

module tb;
    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic [7:0] in_byte    = 8'h01;
    logic       in_last    = 1'b0;
    logic       out_stall  = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       token_end;

    bit calm = 1'b0;
    int items_sent = 0;
    int strings_sent = 0;
    argument_scoreboard sb = new();

    quoted_argument_splitter u_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .token_end  (token_end)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: check accepted results and stall at random.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_byte, byte_valid, token_end);
        out_stall <= !calm && ($urandom_range(0, 99) < 20);
    end

    task automatic send_item(input logic [7:0] b, input logic last);
        if (!calm && $urandom_range(0, 99) < 20)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= last;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        sb.note_input(b, last);
        items_sent++;
    endtask

    task automatic send_string(input byte_q_t bytes);
        foreach (bytes[i])
            send_item(bytes[i], i == bytes.size() - 1);
        strings_sent++;
    endtask

    function automatic byte_q_t to_bytes(input string s);
        byte_q_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (is_separator(b) || b == qas_pkg::CHAR_DQUOTE ||
               b == qas_pkg::CHAR_SQUOTE || b == qas_pkg::CHAR_BACKSLASH);
        return b;
    endfunction

    function automatic logic [7:0] blank_byte();
        case ($urandom_range(0, 3))
            0: return qas_pkg::CHAR_SPACE;
            1: return qas_pkg::CHAR_TAB;
            2: return qas_pkg::CHAR_CR;
            default: return qas_pkg::CHAR_LF;
        endcase
    endfunction

    // Body of a quoted section: plain bytes, some of the other quote kind,
    // some blanks and some escapes.
    task automatic fill_quoted(ref byte_q_t q, input logic [7:0] other_quote);
        repeat ($urandom_range(0, 4))
        begin
            case ($urandom_range(0, 5))
                0: q.push_back(other_quote);
                1:
                begin
                    q.push_back(qas_pkg::CHAR_BACKSLASH);
                    q.push_back(8'($urandom_range(1, 255)));
                end
                2: q.push_back(blank_byte());
                default: q.push_back(plain_byte());
            endcase
        end
    endtask

    initial
    begin
        byte_q_t str;
        int      random_items;
        int      kind;
        random_items = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: byte extremes, every blank kind, both quote kinds with the
        // other kind inside, escaped blank and backslash, a trailing backslash,
        // a string ending on an opening quote, and an empty quoted argument.
        send_string(to_bytes("\001a\tb\377"));
        send_string(to_bytes(" \"x'y\""));
        send_string(to_bytes("'a\"'\015\n"));
        send_string(to_bytes("\\ \\\\\\"));
        send_string(to_bytes("\""));
        send_string(to_bytes("''"));

        while (random_items < 900)
        begin
            calm = (random_items >= 300) && (random_items < 450);
            str.delete();
            repeat ($urandom_range(1, 6))
            begin
                kind = $urandom_range(0, 99);
                if (kind < 30)
                    repeat ($urandom_range(1, 4)) str.push_back(plain_byte());
                else if (kind < 45)
                    repeat ($urandom_range(1, 3)) str.push_back(blank_byte());
                else if (kind < 60)
                begin
                    str.push_back(qas_pkg::CHAR_DQUOTE);
                    fill_quoted(str, qas_pkg::CHAR_SQUOTE);
                    if ($urandom_range(0, 9) != 0)
                        str.push_back(qas_pkg::CHAR_DQUOTE);
                end
                else if (kind < 72)
                begin
                    str.push_back(qas_pkg::CHAR_SQUOTE);
                    fill_quoted(str, qas_pkg::CHAR_DQUOTE);
                    if ($urandom_range(0, 9) != 0)
                        str.push_back(qas_pkg::CHAR_SQUOTE);
                end
                else if (kind < 85)
                begin
                    str.push_back(qas_pkg::CHAR_BACKSLASH);
                    str.push_back(8'($urandom_range(1, 255)));
                end
                else
                    str.push_back(8'($urandom_range(1, 255)));
            end
            if ($urandom_range(0, 9) == 0)
                str.push_back(qas_pkg::CHAR_BACKSLASH);
            send_string(str);
            random_items += str.size();
        end
        in_valid <= 1'b0;
        calm = 1'b0;

        for (int w = 0; w < 2000 && sb.expected_q.size() > 0; w++)
            @(posedge clk);
        repeat (5) @(posedge clk);

        if (sb.expected_q.size() > 0)
        begin
            $display("ERROR: %0d expected results never arrived", sb.expected_q.size());
            sb.errors += sb.expected_q.size();
        end

        $display("Sent %0d strings (%0d bytes) with quotes, escapes and blanks;",
                 strings_sent, items_sent);
        $display("checked %0d results, %0d errors.", sb.results_checked, sb.errors);
        if (sb.errors == 0)
            $display("quoted_argument_splitter test passed");
        else
            $display("quoted_argument_splitter test failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("quoted_argument_splitter test failed");
        $finish;
    end
endmodule

@@ sim.f @@
rtl/core/qas_pkg.sv
rtl/core/quoted_argument_splitter.sv
bench/tb.sv
